// ===== rtl/core/hbs_pkg.sv =====
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 8;
    localparam int GAIN_W     = 12;
    localparam int GAIN_FRAC  = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    localparam logic [DIM_W-1:0]  WIDTH_RST  = 8'd90;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 8'd90;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 12'd512;

    // window sum and divide by 9: floor(s / 9) == (s * 7282) >> 16 for s <= 9 * 255
    localparam int RSUM_W     = PIX_W + 2;
    localparam int SUM_W      = PIX_W + 4;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_SHIFT = 16;

    localparam int GX_W       = GAIN_W + PIX_W;
    localparam int DIFF_W     = GX_W + 1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

endpackage

// ===== rtl/core/high_boost_sharpen_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 high-boost sharpening on an 8-bit grayscale raster stream.
// Slave side: one pixel per transaction in s_tdata, s_tuser = 1 marks a flush
// tick sent after the last pixel of a frame until the frame_end result is out.
// Master side: sharpened pixel in m_tdata, m_tlast on the last pixel of a frame.
// cfg_we/cfg_index/cfg_data write width (0), height (1) and Q4.8 gain (2); write
// them only while no pixel is in flight.
// Results trail the input by one line plus one pixel. The item that completes a
// result passes the stage 1 (line RAM read), stage 2 (window update), stage 3 (sum and
// gain multiply), stage 4 (divide by 9) and output (clamp) registers before m_tvalid.
// Throughput is one transaction per cycle on both sides while not stalled; the line RAM
// reads and writes one column per cycle while not stalled, with a bypass for single-pixel lines.
// Reset clears the counters, the window and the pipeline valid bits and loads the
// default registers (90 x 90, gain 2.0); line RAM contents are masked at the top.
// When m_tready is low with a result held, the whole pipeline and s_tready stall;
// nothing is lost or repeated.

module high_boost_sharpen_3x3
    import hbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // [7:0] pixel_in
    input  logic                  s_tuser,     // [0] flush
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,     // [7:0] pixel_out
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;

    // frame counters
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [DIM_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [DIM_W-1:0]  out_row_reg, out_row_next;
    logic              clr_pend_reg, clr_pend_next;

    // input stage
    logic              en;
    logic              accept;
    logic              enter;
    logic              restart;
    logic [COL_W-1:0]  ic;
    logic [DIM_W-1:0]  ir;
    logic [COL_W-1:0]  oc;
    logic [DIM_W-1:0]  orow;
    logic              ignore_item;
    pix_t              pix_a;
    logic              emit_a;
    logic              last_a;
    logic              in_wrap;
    logic              out_wrap;

    // stage 1: line RAM data
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic              s1_clr_reg;
    logic              s1_col0_reg;
    logic              s1_top_en_reg;
    logic              s1_mid_en_reg;
    pix_t              s1_pix_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    logic              s1_fwd_reg;
    logic [2*PIX_W-1:0] s1_fwd_data_reg;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] line_data;
    logic [2*PIX_W-1:0] line_wdata;
    logic              line_we;
    logic              fwd_hit;
    pix_t              top_pix;
    pix_t              mid_pix;
    pix_t              new_col [3];

    win_t              win_reg, win_next;
    win_t              win_base;
    win_t              win_snap;

    // stage 2: window snapshot
    logic              s2_valid_reg;
    logic              s2_emit_reg;
    logic              s2_last_reg;
    win_t              s2_win_reg;
    logic [RSUM_W-1:0] row_sum [3];
    logic [SUM_W-1:0]  win_sum;
    logic [GX_W-1:0]   gx_s2;

    // stage 3: sum and gain product
    logic              s3_valid_reg;
    logic              s3_emit_reg;
    logic              s3_last_reg;
    logic [SUM_W-1:0]  s3_sum_reg;
    logic [GX_W-1:0]   s3_gx_reg;
    logic [PROD_W-1:0] div_prod;

    // stage 4: mean
    logic              s4_valid_reg;
    logic              s4_emit_reg;
    logic              s4_last_reg;
    pix_t              s4_mean_reg;
    logic [GX_W-1:0]   s4_gx_reg;
    logic [DIFF_W-1:0] diff;
    pix_t              sharp_pix;

    // output register
    logic              out_valid_reg;
    pix_t              out_pix_reg;
    logic              out_last_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // input stage: frame position, padding and counter update
    always_comb
    begin
        restart     = out_row_reg >= h_eff;
        ic          = restart ? '0 : in_col_reg;
        ir          = restart ? '0 : in_row_reg;
        oc          = restart ? '0 : out_col_reg;
        orow        = restart ? '0 : out_row_reg;
        ignore_item = s_tuser && (ir < h_eff);
        pix_a       = (s_tuser || ir >= h_eff) ? '0 : s_tdata;
        emit_a      = (ir >= DIM_W'(2)) || (ir == DIM_W'(1) && ic != '0);
        in_wrap     = (DIM_W'(ic) + DIM_W'(1)) >= w_eff;
        out_wrap    = (DIM_W'(oc) + DIM_W'(1)) >= w_eff;
        last_a      = emit_a && out_wrap
                      && ((DIM_W+1)'(orow) + (DIM_W+1)'(1)) >= (DIM_W+1)'(h_eff);
        enter       = accept && !ignore_item;

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        clr_pend_next = clr_pend_reg;

        if (accept)
        begin
            if (ignore_item)
            begin
                in_col_next   = ic;
                in_row_next   = ir;
                out_col_next  = oc;
                out_row_next  = orow;
                clr_pend_next = clr_pend_reg || restart;
            end
            else
            begin
                clr_pend_next = 1'b0;
                in_col_next   = in_wrap ? '0 : ic + COL_W'(1);
                in_row_next   = in_wrap ? ir + DIM_W'(1) : ir;
                out_col_next  = oc;
                out_row_next  = orow;
                if (emit_a)
                begin
                    out_col_next = out_wrap ? '0 : oc + COL_W'(1);
                    out_row_next = out_wrap ? orow + DIM_W'(1) : orow;
                end
                if (last_a)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    // line RAM: {upper, middle} per column, read at accept, written from the stage 1 registers
    hbs_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr_reg),
        .wdata (line_wdata),
        .re    (en),
        .raddr (ic),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        line_data  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        top_pix    = s1_top_en_reg ? line_data[2*PIX_W-1:PIX_W] : '0;
        mid_pix    = s1_mid_en_reg ? line_data[PIX_W-1:0] : '0;
        line_wdata = {mid_pix, s1_pix_reg};
        line_we    = en && s1_valid_reg;
        fwd_hit    = s1_valid_reg && (s1_addr_reg == ic);

        new_col[0] = top_pix;
        new_col[1] = mid_pix;
        new_col[2] = s1_pix_reg;

        win_base = s1_clr_reg ? '0 : win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_snap[r][0] = win_base[r][1];
            win_snap[r][1] = win_base[r][2];
            win_snap[r][2] = s1_col0_reg ? '0 : new_col[r];
        end

        win_next = win_snap;
        if (s1_col0_reg)
        begin
            win_next = '0;
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][2] = new_col[r];
            end
        end
        if (s1_last_reg)
        begin
            win_next = '0;
        end
    end

    // window sum and center times gain
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = RSUM_W'(s2_win_reg[r][0]) + RSUM_W'(s2_win_reg[r][1])
                         + RSUM_W'(s2_win_reg[r][2]);
        end
        win_sum = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
        gx_s2   = GX_W'(gain_reg) * GX_W'(s2_win_reg[1][1]);
    end

    assign div_prod = PROD_W'(s3_sum_reg) * PROD_W'(DIV9_MUL);

    // gain * x - 256 * mean, then truncate and clamp
    always_comb
    begin
        diff = DIFF_W'(s4_gx_reg) - DIFF_W'({s4_mean_reg, {GAIN_FRAC{1'b0}}});
        if (diff[DIFF_W-1])
            sharp_pix = '0;
        else if (diff[DIFF_W-2:GAIN_FRAC+PIX_W] != '0)
            sharp_pix = '1;
        else
            sharp_pix = diff[GAIN_FRAC+PIX_W-1:GAIN_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            win_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            clr_pend_reg <= clr_pend_next;
            if (en)
            begin
                s1_valid_reg  <= enter;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg && s4_emit_reg;
                if (s1_valid_reg)
                begin
                    win_reg <= win_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg     <= emit_a;
            s1_last_reg     <= last_a;
            s1_clr_reg      <= restart || clr_pend_reg;
            s1_col0_reg     <= (ic == '0);
            s1_top_en_reg   <= (ir >= DIM_W'(2));
            s1_mid_en_reg   <= (ir != '0);
            s1_pix_reg      <= pix_a;
            s1_addr_reg     <= ic;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= line_wdata;

            s2_emit_reg     <= s1_emit_reg;
            s2_last_reg     <= s1_last_reg;
            s2_win_reg      <= win_snap;

            s3_emit_reg     <= s2_emit_reg;
            s3_last_reg     <= s2_last_reg;
            s3_sum_reg      <= win_sum;
            s3_gx_reg       <= gx_s2;

            s4_emit_reg     <= s3_emit_reg;
            s4_last_reg     <= s3_last_reg;
            s4_mean_reg     <= div_prod[DIV9_SHIFT +: PIX_W];
            s4_gx_reg       <= s3_gx_reg;

            out_pix_reg     <= sharp_pix;
            out_last_reg    <= s4_last_reg;
        end
    end

endmodule

// ===== rtl/core/hbs_ram.sv =====
`timescale 1ns / 1ps

module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
